[hw/rtl/qedl_pkg.sv]
// Shared types, constants and register indexes of the embedding dequantisation lookup core.
package qedl_pkg;

    localparam int MAX_ROWS       = 1024;
    localparam int MAX_ROW_LENGTH = 256;
    localparam int MIN_BLOCK      = 32;

    localparam int WEIGHT_DEPTH = MAX_ROWS * MAX_ROW_LENGTH;
    localparam int SCALE_DEPTH  = WEIGHT_DEPTH / MIN_BLOCK;
    localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
    localparam int SADDR_W      = $clog2(SCALE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_MODE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT_SHARED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH        = 3'd5;

    localparam int DIV_STEPS   = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        FN_WR_WEIGHT = 2'd0,
        FN_WR_SCALE  = 2'd1,
        FN_WR_ZP     = 2'd2,
        FN_LOOKUP    = 2'd3
    } func_t;

    typedef struct packed {
        logic        element_type;
        logic        quant_mode;
        logic [8:0]  block_len;
        logic        zero_point_shared;
        logic [10:0] row_count;
        logic [8:0]  row_length;
    } cfg_t;

    typedef struct packed {
        func_t              func;
        logic [WADDR_W-1:0] waddr;
        logic [SADDR_W-1:0] saddr;
        logic [SADDR_W-1:0] zaddr;
        logic [31:0]        wdata;
        logic               col_odd;
        logic               clamped;
    } qitem_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic almost_full;
    } qstat_t;

endpackage

[hw/rtl/qedl_ram.sv]
// Generic single-port RAM with registered read data.
module qedl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/qedl_front.sv]
// Front end: accepts items, clamps the token, divides by the block size and forms store addresses.
module qedl_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qedl_pkg::cfg_t                   cfg,
    input  logic                             take,
    input  logic [1:0]                       func,
    input  logic [17:0]                      address,
    input  logic [31:0]                      write_data,
    input  logic signed [31:0]               token,
    input  logic [7:0]                       column,
    output logic                             push,
    output qedl_pkg::qitem_t                 item
);
    import qedl_pkg::*;

    typedef struct packed {
        func_t       func;
        logic [17:0] address;
        logic [31:0] wdata;
        logic [10:0] row;
        logic [7:0]  col;
        logic        clamped;
        logic [19:0] wbase;
        logic [8:0]  num_col;
        logic [8:0]  rem_col;
        logic [8:0]  num_len;
        logic [8:0]  rem_len;
    } stage_t;

    stage_t             stg_reg  [DIV_STEPS+1];
    stage_t             stg_next [DIV_STEPS+1];
    logic [DIV_STEPS:0] vld_reg;
    qitem_t             item_reg;
    logic               push_reg;
    logic [8:0]         divisor;
    logic               token_bad;
    logic [8:0]         len_mul;

    function automatic stage_t div_step(input stage_t s, input logic [8:0] d);
        stage_t     t;
        logic [9:0] rc;
        logic [9:0] rl;
        t  = s;
        rc = {s.rem_col, s.num_col[8]};
        t.num_col = {s.num_col[7:0], 1'b0};
        if (rc >= {1'b0, d})
        begin
            rc = rc - {1'b0, d};
            t.num_col[0] = 1'b1;
        end
        t.rem_col = rc[8:0];
        rl = {s.rem_len, s.num_len[8]};
        t.num_len = {s.num_len[7:0], 1'b0};
        if (rl >= {1'b0, d})
        begin
            rl = rl - {1'b0, d};
            t.num_len[0] = 1'b1;
        end
        t.rem_len = rl[8:0];
        return t;
    endfunction

    function automatic qitem_t item_next();
        qitem_t             q;
        stage_t             s;
        logic [19:0]        blk;
        logic [SADDR_W-1:0] slot;
        logic [7:0]         off;
        s    = stg_reg[DIV_STEPS];
        blk  = 20'(s.row) * 20'(s.num_len) + 20'(s.num_col);
        slot = cfg.quant_mode ? SADDR_W'(blk) : SADDR_W'(s.row);
        off  = cfg.element_type ? s.col : {1'b0, s.col[7:1]};
        q.func    = s.func;
        q.waddr   = (s.func == FN_WR_WEIGHT) ? WADDR_W'(s.address)
                                             : WADDR_W'({1'b0, s.wbase} + 21'(off));
        q.saddr   = (s.func == FN_WR_SCALE) ? SADDR_W'(s.address) : slot;
        q.zaddr   = (s.func == FN_WR_ZP) ? SADDR_W'(s.address)
                                         : (cfg.zero_point_shared ? '0 : slot);
        q.wdata   = s.wdata;
        q.col_odd = s.col[0];
        q.clamped = s.clamped;
        return q;
    endfunction

    assign divisor   = (cfg.block_len == 9'd0) ? 9'd1 : cfg.block_len;
    assign token_bad = token[31] || (token[30:0] >= 31'(cfg.row_count));
    assign len_mul   = cfg.element_type ? cfg.row_length : {1'b0, cfg.row_length[8:1]};

    always_comb
    begin
        stg_next[0]         = stg_reg[0];
        stg_next[0].func    = func_t'(func);
        stg_next[0].address = address;
        stg_next[0].wdata   = write_data;
        stg_next[0].row     = token_bad ? 11'd0 : token[10:0];
        stg_next[0].col     = column;
        stg_next[0].clamped = token_bad;
        stg_next[0].wbase   = '0;
        stg_next[0].num_col = {1'b0, column};
        stg_next[0].rem_col = '0;
        stg_next[0].num_len = cfg.row_length;
        stg_next[0].rem_len = '0;
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            stg_next[k] = div_step(stg_reg[k-1], divisor);
        end
        stg_next[1].wbase = 20'(stg_reg[0].row) * 20'(len_mul);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            push_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[DIV_STEPS-1:0], take};
            push_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            stg_reg[k] <= stg_next[k];
        end
        item_reg <= item_next();
    end

    assign push = push_reg;
    assign item = item_reg;
endmodule

[hw/rtl/qedl_queue.sv]
// Short queue between the front end and the back end.
module qedl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qedl_pkg::qitem_t din,
    input  logic             pop,
    output qedl_pkg::qitem_t dout,
    output qedl_pkg::qstat_t stat
);
    import qedl_pkg::*;

    qitem_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout             = mem_reg[rd_ptr_reg];
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.almost_full = (count_reg >= (QPTR_W+1)'(QUEUE_DEPTH / 2));
endmodule

[hw/rtl/qedl_back.sv]
// Back end: store accesses, element extraction, zero-point subtraction and the FP32 multiply with rounding.
module qedl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  qedl_pkg::cfg_t   cfg,
    input  qedl_pkg::qitem_t item,
    input  logic             avail,
    output logic             pop,
    output logic             done,
    output logic [31:0]      value,
    output logic             clamped
);
    import qedl_pkg::*;

    logic [7:0]  w_rdata;
    logic [31:0] s_rdata;
    logic [7:0]  z_rdata;

    logic        s1_vld_reg, s1_odd_reg, s1_clamp_reg;
    logic        s2_vld_reg, s2_clamp_reg, s2_sign_reg, s2_nan_reg, s2_inf_reg, s2_zero_reg;
    logic [7:0]  s2_e_reg;
    logic [31:0] s2_prod_reg;
    logic        s3_vld_reg, s3_clamp_reg, s3_sign_reg, s3_nan_reg, s3_inf_reg, s3_zero_reg;
    logic [7:0]  s3_e_reg;
    logic [31:0] s3_prod_reg;
    logic [4:0]  s3_pos_reg;
    logic        done_reg, clamped_reg;
    logic [31:0] value_reg;

    logic [9:0]  elem, diff, mag_w;
    logic [7:0]  mag;
    logic [7:0]  sexp;
    logic [22:0] sman;
    logic        nan2, inf2, zero2;
    logic [4:0]  pos;
    logic signed [10:0] be;
    logic [31:0] frac;
    logic [5:0]  rs;
    logic [63:0] wide;
    logic [7:0]  expf;
    logic        rnd;
    logic [30:0] packed_v;
    logic [31:0] value_next;

    assign pop = avail;

    qedl_ram #(.WIDTH(8), .DEPTH(WEIGHT_DEPTH)) u_weight (
        .clk(clk), .we(avail && item.func == FN_WR_WEIGHT), .addr(item.waddr),
        .wdata(item.wdata[7:0]), .rdata(w_rdata)
    );
    qedl_ram #(.WIDTH(32), .DEPTH(SCALE_DEPTH)) u_scale (
        .clk(clk), .we(avail && item.func == FN_WR_SCALE), .addr(item.saddr),
        .wdata(item.wdata), .rdata(s_rdata)
    );
    qedl_ram #(.WIDTH(8), .DEPTH(SCALE_DEPTH)) u_zero (
        .clk(clk), .we(avail && item.func == FN_WR_ZP), .addr(item.zaddr),
        .wdata(item.wdata[7:0]), .rdata(z_rdata)
    );

    always_comb
    begin
        if (cfg.element_type)
        begin
            elem = {{2{w_rdata[7]}}, w_rdata};
        end
        else if (s1_odd_reg)
        begin
            elem = {{6{w_rdata[7]}}, w_rdata[7:4]};
        end
        else
        begin
            elem = {{6{w_rdata[3]}}, w_rdata[3:0]};
        end
        diff  = elem - {{2{z_rdata[7]}}, z_rdata};
        mag_w = diff[9] ? (10'd0 - diff) : diff;
        mag   = mag_w[7:0];
        sexp  = s_rdata[30:23];
        sman  = s_rdata[22:0];
        nan2  = (sexp == 8'hFF) && ((sman != '0) || (mag == 8'd0));
        inf2  = (sexp == 8'hFF) && !nan2;
        zero2 = (sexp != 8'hFF) && ((mag == 8'd0) || ((sexp == 8'd0) && (sman == '0)));
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (s2_prod_reg[i])
            begin
                pos = 5'(i);
            end
        end
    end

    always_comb
    begin
        be   = $signed({3'b000, s3_e_reg}) + $signed({6'b0, s3_pos_reg}) - 11'sd23;
        frac = s3_prod_reg << (5'd31 - s3_pos_reg);
        rs   = (be < 11'sd1) ? 6'(11'sd1 - be) : 6'd0;
        wide = {frac, 32'b0} >> rs;
        expf = (be < 11'sd1) ? 8'd0 : be[7:0];
        rnd  = wide[39] && ((|wide[38:0]) || wide[40]);
        packed_v = {expf, wide[62:40]} + 31'(rnd);
        if (s3_nan_reg)
        begin
            value_next = 32'h7FC00000;
        end
        else if (s3_inf_reg || (be >= 11'sd255))
        begin
            value_next = {s3_sign_reg, 8'hFF, 23'b0};
        end
        else if (s3_zero_reg)
        begin
            value_next = {s3_sign_reg, 31'b0};
        end
        else
        begin
            value_next = {s3_sign_reg, packed_v};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= avail && (item.func == FN_LOOKUP);
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            done_reg   <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_odd_reg   <= item.col_odd;
        s1_clamp_reg <= item.clamped;
        s2_clamp_reg <= s1_clamp_reg;
        s2_sign_reg  <= diff[9] ^ s_rdata[31];
        s2_nan_reg   <= nan2;
        s2_inf_reg   <= inf2;
        s2_zero_reg  <= zero2;
        s2_e_reg     <= (sexp == 8'd0) ? 8'd1 : sexp;
        s2_prod_reg  <= 32'(mag) * 32'({(sexp != 8'd0), sman});
        s3_clamp_reg <= s2_clamp_reg;
        s3_sign_reg  <= s2_sign_reg;
        s3_nan_reg   <= s2_nan_reg;
        s3_inf_reg   <= s2_inf_reg;
        s3_zero_reg  <= s2_zero_reg;
        s3_e_reg     <= s2_e_reg;
        s3_prod_reg  <= s2_prod_reg;
        s3_pos_reg   <= pos;
        value_reg    <= value_next;
        clamped_reg  <= s3_clamp_reg;
    end

    assign done    = done_reg;
    assign value   = value_reg;
    assign clamped = clamped_reg;
endmodule

[hw/rtl/quantized_embedding_dequant_lookup_core.sv]
// Top level of the quantised embedding lookup core with affine FP32 dequantisation.
// A lookup passes the pipelined nine-step block-size divider, the queue and the back end.
// Throughput: one transfer per cycle while busy is low.
// Write transfers give no result and take the same path to keep store order.
// Reset clears control state and loads the register defaults; the stores are not cleared.
// The receiver cannot stall, so the back end drains the queue every cycle.
module quantized_embedding_dequant_lookup_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic [17:0]                         address,
    input  logic [31:0]                         write_data,
    input  logic signed [31:0]                  token,
    input  logic [7:0]                          column,
    output logic                                done,
    output logic [31:0]                         value,
    output logic                                clamped,
    input  logic                                cfg_we,
    input  logic [qedl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qedl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import qedl_pkg::*;

    localparam int PIPE_LATENCY = DIV_STEPS + 7;

    cfg_t   cfg_reg;
    logic   take;
    logic   q_push;
    qitem_t q_din;
    qitem_t q_dout;
    qstat_t q_stat;
    logic   q_pop;

    assign busy = q_stat.almost_full;
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.element_type      <= 1'b1;
            cfg_reg.quant_mode        <= 1'b0;
            cfg_reg.block_len         <= 9'd32;
            cfg_reg.zero_point_shared <= 1'b1;
            cfg_reg.row_count         <= 11'd1024;
            cfg_reg.row_length        <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ELEMENT_TYPE:      cfg_reg.element_type      <= cfg_data[0];
                REG_QUANT_MODE:        cfg_reg.quant_mode        <= cfg_data[0];
                REG_BLOCK_SIZE:        cfg_reg.block_len         <= cfg_data[8:0];
                REG_ZERO_POINT_SHARED: cfg_reg.zero_point_shared <= cfg_data[0];
                REG_ROW_COUNT:         cfg_reg.row_count         <= cfg_data[10:0];
                REG_ROW_LENGTH:        cfg_reg.row_length        <= cfg_data[8:0];
                default:               ;
            endcase
        end
    end

    qedl_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .take(take), .func(func),
        .address(address), .write_data(write_data), .token(token),
        .column(column), .push(q_push), .item(q_din)
    );

    qedl_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .pop(q_pop),
        .dout(q_dout), .stat(q_stat)
    );

    qedl_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .item(q_dout), .avail(!q_stat.empty),
        .pop(q_pop), .done(done), .value(value), .clamped(clamped)
    );

    a_lookup_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && (func == FN_LOOKUP) |-> ##PIPE_LATENCY done)
        else $error("lookup transfer gave no result");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        take && (func != FN_LOOKUP) |-> ##PIPE_LATENCY !done)
        else $error("write transfer gave a result");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue overflow");
endmodule
